// File: rtl/opu_pkg.sv
// ----------------------------------------------------------------------------
// Optimizer update unit package
// Shared widths, register codes, reset values and pipeline depths.
// ----------------------------------------------------------------------------
package opu_pkg;

	// Field and register widths.
	localparam int VAL_W  = 32;
	localparam int UVAL_W = 31;
	localparam int FRAC   = 24;
	localparam int REG_W  = 24;
	localparam int IDX_W  = 3;

	// One in unsigned Q0.24, as a 25-bit value.
	localparam logic [REG_W:0] ONE_Q = 25'h100_0000;

	// Register indexes on the write port.
	typedef enum logic [IDX_W-1:0] {
		REG_MODE   = 3'd0,
		REG_STEP   = 3'd1,
		REG_DECAY1 = 3'd2,
		REG_DECAY2 = 3'd3,
		REG_EPS    = 3'd4
	} cfg_reg_t;

	// Reset values of the registers.
	localparam logic [REG_W-1:0] RST_STEP   = 24'd167772;
	localparam logic [REG_W-1:0] RST_DECAY1 = 24'd15099494;
	localparam logic [REG_W-1:0] RST_DECAY2 = 24'd16760438;
	localparam logic [REG_W-1:0] RST_EPS    = 24'd1;

	// Long division of a 64-bit dividend by a 25-bit divisor.
	localparam int DIV_N_W     = 64;
	localparam int DIV_D_W     = 25;
	localparam int DIV_PER_STG = 4;
	localparam int DIV_STAGES  = DIV_N_W / DIV_PER_STG;

	// Digit-by-digit square root of a 64-bit value.
	localparam int SQ_IN_W     = 64;
	localparam int SQ_ROOT_W   = 32;
	localparam int SQ_REM_W    = 34;
	localparam int SQ_PER_STG  = 4;
	localparam int SQ_STAGES   = SQ_ROOT_W / SQ_PER_STG;

	// Final scaled division: 33 quotient bits over a 41-bit denominator.
	localparam int DEN_W       = 41;
	localparam int QUO_W       = 33;
	localparam int T_W         = 55;
	localparam int QD_PER_STG  = 3;
	localparam int QD_STAGES   = QUO_W / QD_PER_STG;
	localparam int QDIV_LAT    = QD_STAGES + 2;

	// Overall pipeline depth from accepted start to done.
	localparam int FRONT_LAT   = 6;
	localparam int SIDE_LAT    = DIV_STAGES + SQ_STAGES + QDIV_LAT;
	localparam int TOTAL_LAT   = FRONT_LAT + SIDE_LAT + 1;

	// Update magnitude cap, two to the 32nd.
	localparam logic [QUO_W-1:0] DELTA_CAP = 33'h1_0000_0000;

	// Signed range limits.
	localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
	localparam logic [UVAL_W-1:0]       UVAL_MAX = 31'h7FFF_FFFF;

	// Configuration as seen by the datapath.
	typedef struct packed {
		logic             mode;
		logic [REG_W-1:0] step;
		logic [REG_W-1:0] decay1;
		logic [REG_W-1:0] decay2;
		logic [REG_W-1:0] eps;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		mode:   1'b0,
		step:   RST_STEP,
		decay1: RST_DECAY1,
		decay2: RST_DECAY2,
		eps:    RST_EPS
	};

	// Per-item values that ride along the long division and root chain.
	typedef struct packed {
		logic                     mode;
		logic signed [VAL_W-1:0]  p;
		logic signed [VAL_W-1:0]  nm;
		logic [UVAL_W-1:0]        nv;
		logic                     flag;
		logic signed [VAL_W-1:0]  np_desc;
		logic [4:0]               shift_a;
	} side_t;

endpackage

// File: rtl/opu_front.sv
// ----------------------------------------------------------------------------
// Optimizer update front end
// Six stages: products, moment updates with saturation, the descent result,
// the step product and the normalized dividend for the root path.
// ----------------------------------------------------------------------------
module opu_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_vld,
	input  logic signed [opu_pkg::VAL_W-1:0]    param_value,
	input  logic signed [opu_pkg::VAL_W-1:0]    gradient,
	input  logic signed [opu_pkg::VAL_W-1:0]    first_moment,
	input  logic [opu_pkg::UVAL_W-1:0]          second_moment,
	input  opu_pkg::cfg_t                       cfg,
	output logic                                out_vld,
	output logic [opu_pkg::DIV_N_W-1:0]         vdiv,
	output logic [55:0]                         tprod,
	output opu_pkg::side_t                      side
);

	// Stage 1: magnitudes and all first-level products.
	logic        g_neg_c;
	logic [31:0] gabs_c;
	logic [24:0] d1_c;
	logic signed [56:0] b1m_c;
	logic signed [57:0] d1g_c;
	logic [55:0] dprod_c;
	logic [63:0] gg_c;
	logic [54:0] b2v_c;

	always_comb begin
		g_neg_c = gradient[31];
		gabs_c  = g_neg_c ? 32'(-gradient) : 32'(gradient);
		d1_c    = opu_pkg::ONE_Q - {1'b0, cfg.decay1};
		b1m_c   = 57'($signed({1'b0, cfg.decay1})) * 57'(first_moment);
		d1g_c   = 58'($signed({1'b0, d1_c})) * 58'(gradient);
		dprod_c = 56'(gabs_c) * 56'(cfg.step);
		gg_c    = 64'(gabs_c) * 64'(gabs_c);
		b2v_c   = 55'(cfg.decay2) * 55'(second_moment);
	end

	logic        vld_s1, mode_s1, g_neg_s1;
	logic signed [31:0] p_s1, m_s1;
	logic [30:0] v_s1;
	logic signed [56:0] b1m_s1;
	logic signed [57:0] d1g_s1;
	logic [55:0] dprod_s1;
	logic [63:0] gg_s1;
	logic [54:0] b2v_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		mode_s1  <= cfg.mode;
		g_neg_s1 <= g_neg_c;
		p_s1     <= param_value;
		m_s1     <= first_moment;
		v_s1     <= second_moment;
		b1m_s1   <= b1m_c;
		d1g_s1   <= d1g_c;
		dprod_s1 <= dprod_c;
		gg_s1    <= gg_c;
		b2v_s1   <= b2v_c;
	end

	// Stage 2: first moment with truncation toward zero, descent result.
	logic signed [58:0] msum_c;
	logic        mneg_c;
	logic [58:0] mmag_c;
	logic [34:0] mshift_c;
	logic signed [31:0] nm_sat_c;
	logic        flagm_c;
	logic [31:0] dd_c;
	logic signed [33:0] ddiff_c;
	logic signed [31:0] np_desc_c;
	logic        flagd_c;

	always_comb begin
		msum_c   = {{2{b1m_s1[56]}}, b1m_s1} + {d1g_s1[57], d1g_s1};
		mneg_c   = msum_c[58];
		mmag_c   = mneg_c ? 59'(-msum_c) : 59'(msum_c);
		mshift_c = mmag_c[58:24];
		flagm_c  = 1'b0;
		if (!mneg_c) begin
			if (mshift_c > 35'h0_7FFF_FFFF) begin
				nm_sat_c = opu_pkg::VAL_MAX;
				flagm_c  = 1'b1;
			end else begin
				nm_sat_c = $signed(mshift_c[31:0]);
			end
		end else begin
			if (mshift_c > 35'h0_8000_0000) begin
				nm_sat_c = opu_pkg::VAL_MIN;
				flagm_c  = 1'b1;
			end else begin
				nm_sat_c = $signed(32'(-mshift_c[31:0]));
			end
		end

		dd_c    = dprod_s1[55:24];
		ddiff_c = g_neg_s1 ? ({{2{p_s1[31]}}, p_s1} + {2'b00, dd_c})
		                   : ({{2{p_s1[31]}}, p_s1} - {2'b00, dd_c});
		flagd_c = 1'b0;
		if (ddiff_c > 34'sh0_7FFF_FFFF) begin
			np_desc_c = opu_pkg::VAL_MAX;
			flagd_c   = 1'b1;
		end else if (ddiff_c < -34'sh0_8000_0000) begin
			np_desc_c = opu_pkg::VAL_MIN;
			flagd_c   = 1'b1;
		end else begin
			np_desc_c = ddiff_c[31:0];
		end
	end

	logic        vld_s2, mode_s2, flagm_s2, flagd_s2;
	logic signed [31:0] p_s2, nm_s2, np_desc_s2;
	logic [30:0] v_s2;
	logic [38:0] gsq_s2;
	logic [54:0] b2v_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		mode_s2    <= mode_s1;
		p_s2       <= p_s1;
		nm_s2      <= mode_s1 ? nm_sat_c : m_s1;
		flagm_s2   <= mode_s1 & flagm_c;
		np_desc_s2 <= np_desc_c;
		flagd_s2   <= flagd_c;
		v_s2       <= v_s1;
		gsq_s2     <= gg_s1[62:24];
		b2v_s2     <= b2v_s1;
	end

	// Stage 3: second moment product and the step product for the update.
	logic [24:0] d2_c;
	logic [63:0] d2gsq_c;
	logic [31:0] nmabs_c;
	logic [55:0] tprod_c;

	always_comb begin
		d2_c    = opu_pkg::ONE_Q - {1'b0, cfg.decay2};
		d2gsq_c = 64'(d2_c) * 64'(gsq_s2);
		nmabs_c = nm_s2[31] ? 32'(-nm_s2) : 32'(nm_s2);
		tprod_c = 56'(nmabs_c) * 56'(cfg.step);
	end

	logic        vld_s3, mode_s3, flagm_s3, flagd_s3;
	logic signed [31:0] p_s3, nm_s3, np_desc_s3;
	logic [30:0] v_s3;
	logic [63:0] d2gsq_s3;
	logic [54:0] b2v_s3;
	logic [55:0] tprod_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		mode_s3    <= mode_s2;
		p_s3       <= p_s2;
		nm_s3      <= nm_s2;
		flagm_s3   <= flagm_s2;
		np_desc_s3 <= np_desc_s2;
		flagd_s3   <= flagd_s2;
		v_s3       <= v_s2;
		d2gsq_s3   <= d2gsq_c;
		b2v_s3     <= b2v_s2;
		tprod_s3   <= tprod_c;
	end

	// Stage 4: second moment sum, scale and saturation.
	logic [63:0] vsum_c;
	logic [39:0] nvfull_c;
	logic [30:0] nv_sat_c;
	logic        flagv_c;

	always_comb begin
		vsum_c   = 64'(b2v_s3) + d2gsq_s3;
		nvfull_c = vsum_c[63:24];
		flagv_c  = 1'b0;
		if (nvfull_c > 40'(opu_pkg::UVAL_MAX)) begin
			nv_sat_c = opu_pkg::UVAL_MAX;
			flagv_c  = 1'b1;
		end else begin
			nv_sat_c = nvfull_c[30:0];
		end
	end

	logic        vld_s4, mode_s4, flag_s4;
	logic signed [31:0] p_s4, nm_s4, np_desc_s4;
	logic [30:0] nv_s4;
	logic [55:0] tprod_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		mode_s4    <= mode_s3;
		p_s4       <= p_s3;
		nm_s4      <= nm_s3;
		np_desc_s4 <= np_desc_s3;
		nv_s4      <= mode_s3 ? nv_sat_c : v_s3;
		flag_s4    <= mode_s3 ? (flagm_s3 | flagv_c) : flagd_s3;
		tprod_s4   <= tprod_s3;
	end

	// Stage 5: largest even pre-shift, at most 48 bits, that keeps the radicand in 64 bits.
	logic [4:0] len_c;
	logic [4:0] a_c;

	always_comb begin
		len_c = '0;
		for (int i = 0; i < opu_pkg::UVAL_W; i++) begin
			if (nv_s4[i]) begin
				len_c = 5'(i + 1);
			end
		end
		a_c = (len_c <= 5'd16) ? 5'd24 : 5'((7'd64 - 7'(len_c)) >> 1);
	end

	logic        vld_s5;
	opu_pkg::side_t side_s5;
	logic [55:0] tprod_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else begin
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		side_s5.mode    <= mode_s4;
		side_s5.p       <= p_s4;
		side_s5.nm      <= nm_s4;
		side_s5.nv      <= nv_s4;
		side_s5.flag    <= flag_s4;
		side_s5.np_desc <= np_desc_s4;
		side_s5.shift_a <= a_c;
		tprod_s5        <= tprod_s4;
	end

	// Stage 6: pre-shifted radicand dividend.
	logic        vld_s6;
	opu_pkg::side_t side_s6;
	logic [55:0] tprod_s6;
	logic [63:0] vdiv_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
		end else begin
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		side_s6  <= side_s5;
		tprod_s6 <= tprod_s5;
		vdiv_s6  <= 64'(side_s5.nv) << {side_s5.shift_a, 1'b0};
	end

	assign out_vld = vld_s6;
	assign vdiv    = vdiv_s6;
	assign tprod   = tprod_s6;
	assign side    = side_s6;

endmodule

// File: rtl/opu_div.sv
// ----------------------------------------------------------------------------
// Optimizer update pipelined divider
// Restoring long division, 64-bit dividend over a 25-bit divisor, four
// quotient bits per stage.
// ----------------------------------------------------------------------------
module opu_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_vld,
	input  logic [opu_pkg::DIV_N_W-1:0]       dividend,
	input  logic [opu_pkg::DIV_D_W-1:0]       divisor,
	output logic                              out_vld,
	output logic [opu_pkg::DIV_N_W-1:0]       quotient
);

	logic                            vld_s [opu_pkg::DIV_STAGES];
	logic [opu_pkg::DIV_D_W-1:0]     rem_s [opu_pkg::DIV_STAGES];
	logic [opu_pkg::DIV_N_W-1:0]     nq_s  [opu_pkg::DIV_STAGES];
	logic [opu_pkg::DIV_D_W-1:0]     dvs_s [opu_pkg::DIV_STAGES];

	for (genvar s = 0; s < opu_pkg::DIV_STAGES; s++) begin : g_stage
		logic                        vld_in;
		logic [opu_pkg::DIV_D_W-1:0] rem_in, rem_c, dvs_in;
		logic [opu_pkg::DIV_N_W-1:0] nq_in, nq_c;

		if (s == 0) begin : g_first
			assign vld_in = in_vld;
			assign rem_in = '0;
			assign nq_in  = dividend;
			assign dvs_in = divisor;
		end else begin : g_next
			assign vld_in = vld_s[s-1];
			assign rem_in = rem_s[s-1];
			assign nq_in  = nq_s[s-1];
			assign dvs_in = dvs_s[s-1];
		end

		// Shift in the next dividend bit, subtract when it fits.
		always_comb begin
			logic [opu_pkg::DIV_D_W:0] rt;
			rem_c = rem_in;
			nq_c  = nq_in;
			for (int k = 0; k < opu_pkg::DIV_PER_STG; k++) begin
				rt   = {rem_c, nq_c[opu_pkg::DIV_N_W-1]};
				nq_c = nq_c << 1;
				if (rt >= {1'b0, dvs_in}) begin
					rt      = rt - {1'b0, dvs_in};
					nq_c[0] = 1'b1;
				end
				rem_c = rt[opu_pkg::DIV_D_W-1:0];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[s] <= 1'b0;
			end else begin
				vld_s[s] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			rem_s[s] <= rem_c;
			nq_s[s]  <= nq_c;
			dvs_s[s] <= dvs_in;
		end
	end

	assign out_vld  = vld_s[opu_pkg::DIV_STAGES-1];
	assign quotient = nq_s[opu_pkg::DIV_STAGES-1];

endmodule

// File: rtl/opu_sqrt.sv
// ----------------------------------------------------------------------------
// Optimizer update pipelined square root
// Digit-by-digit integer square root of a 64-bit value, floor result.
// ----------------------------------------------------------------------------
module opu_sqrt (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_vld,
	input  logic [opu_pkg::SQ_IN_W-1:0]       radicand,
	output logic                              out_vld,
	output logic [opu_pkg::SQ_ROOT_W-1:0]     root
);

	logic                             vld_s [opu_pkg::SQ_STAGES];
	logic [opu_pkg::SQ_IN_W-1:0]      x_s   [opu_pkg::SQ_STAGES];
	logic [opu_pkg::SQ_REM_W-1:0]     r_s   [opu_pkg::SQ_STAGES];
	logic [opu_pkg::SQ_ROOT_W-1:0]    q_s   [opu_pkg::SQ_STAGES];

	for (genvar s = 0; s < opu_pkg::SQ_STAGES; s++) begin : g_stage
		logic                          vld_in;
		logic [opu_pkg::SQ_IN_W-1:0]   x_in, x_c;
		logic [opu_pkg::SQ_REM_W-1:0]  r_in, r_c;
		logic [opu_pkg::SQ_ROOT_W-1:0] q_in, q_c;

		if (s == 0) begin : g_first
			assign vld_in = in_vld;
			assign x_in   = radicand;
			assign r_in   = '0;
			assign q_in   = '0;
		end else begin : g_next
			assign vld_in = vld_s[s-1];
			assign x_in   = x_s[s-1];
			assign r_in   = r_s[s-1];
			assign q_in   = q_s[s-1];
		end

		// Bring down two bits, try root digit one against 4q+1.
		always_comb begin
			logic [opu_pkg::SQ_REM_W+1:0] rt;
			logic [opu_pkg::SQ_REM_W+1:0] trial;
			x_c = x_in;
			r_c = r_in;
			q_c = q_in;
			for (int k = 0; k < opu_pkg::SQ_PER_STG; k++) begin
				rt    = {r_c, x_c[opu_pkg::SQ_IN_W-1 -: 2]};
				x_c   = x_c << 2;
				trial = {2'b00, q_c, 2'b01};
				if (rt >= trial) begin
					rt  = rt - trial;
					q_c = {q_c[opu_pkg::SQ_ROOT_W-2:0], 1'b1};
				end else begin
					q_c = {q_c[opu_pkg::SQ_ROOT_W-2:0], 1'b0};
				end
				r_c = rt[opu_pkg::SQ_REM_W-1:0];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[s] <= 1'b0;
			end else begin
				vld_s[s] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			x_s[s] <= x_c;
			r_s[s] <= r_c;
			q_s[s] <= q_c;
		end
	end

	assign out_vld = vld_s[opu_pkg::SQ_STAGES-1];
	assign root    = q_s[opu_pkg::SQ_STAGES-1];

endmodule

// File: rtl/opu_qdiv.sv
// ----------------------------------------------------------------------------
// Optimizer update step divider
// Builds the denominator from the root and epsilon, then divides the scaled
// step product by it, returning 33 quotient bits and an overflow mark.
// ----------------------------------------------------------------------------
module opu_qdiv (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_vld,
	input  logic [opu_pkg::T_W-1:0]           t,
	input  logic [opu_pkg::SQ_ROOT_W-1:0]     root,
	input  logic [4:0]                        shift_a,
	input  logic [opu_pkg::REG_W-1:0]         eps,
	output logic                              out_vld,
	output logic                              ovf,
	output logic [opu_pkg::QUO_W-1:0]         quo
);

	// Stage 1: denominator, with a zero sum forced to one.
	logic [39:0]                  s_c;
	logic [opu_pkg::DEN_W-1:0]    den_c;

	always_comb begin
		s_c   = 40'(root) << (5'd24 - shift_a);
		den_c = {1'b0, s_c} + 41'(eps);
		if (den_c == '0) begin
			den_c = 41'd1;
		end
	end

	logic                         vld_s1;
	logic [opu_pkg::DEN_W-1:0]    den_s1;
	logic [opu_pkg::T_W-1:0]      t_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		den_s1 <= den_c;
		t_s1   <= t;
	end

	// Stage 2: a quotient of 2^33 or more shows in the upper dividend part.
	logic                         vld_s2, ovf_s2;
	logic [opu_pkg::DEN_W-1:0]    den_s2, rem_s2;
	logic [opu_pkg::QUO_W-1:0]    bits_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		ovf_s2  <= (t_s1[54:9] >= 46'(den_s1));
		den_s2  <= den_s1;
		rem_s2  <= t_s1[49:9];
		bits_s2 <= {t_s1[8:0], 24'b0};
	end

	// Remaining stages: restoring steps over the low 33 dividend bits.
	logic                         vld_s [opu_pkg::QD_STAGES];
	logic                         ovf_s [opu_pkg::QD_STAGES];
	logic [opu_pkg::DEN_W-1:0]    den_s [opu_pkg::QD_STAGES];
	logic [opu_pkg::DEN_W-1:0]    rem_s [opu_pkg::QD_STAGES];
	logic [opu_pkg::QUO_W-1:0]    nq_s  [opu_pkg::QD_STAGES];

	for (genvar s = 0; s < opu_pkg::QD_STAGES; s++) begin : g_stage
		logic                      vld_in, ovf_in;
		logic [opu_pkg::DEN_W-1:0] den_in, rem_in, rem_c;
		logic [opu_pkg::QUO_W-1:0] nq_in, nq_c;

		if (s == 0) begin : g_first
			assign vld_in = vld_s2;
			assign ovf_in = ovf_s2;
			assign den_in = den_s2;
			assign rem_in = rem_s2;
			assign nq_in  = bits_s2;
		end else begin : g_next
			assign vld_in = vld_s[s-1];
			assign ovf_in = ovf_s[s-1];
			assign den_in = den_s[s-1];
			assign rem_in = rem_s[s-1];
			assign nq_in  = nq_s[s-1];
		end

		always_comb begin
			logic [opu_pkg::DEN_W:0] rt;
			rem_c = rem_in;
			nq_c  = nq_in;
			for (int k = 0; k < opu_pkg::QD_PER_STG; k++) begin
				rt   = {rem_c, nq_c[opu_pkg::QUO_W-1]};
				nq_c = nq_c << 1;
				if (rt >= {1'b0, den_in}) begin
					rt      = rt - {1'b0, den_in};
					nq_c[0] = 1'b1;
				end
				rem_c = rt[opu_pkg::DEN_W-1:0];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[s] <= 1'b0;
			end else begin
				vld_s[s] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			ovf_s[s] <= ovf_in;
			den_s[s] <= den_in;
			rem_s[s] <= rem_c;
			nq_s[s]  <= nq_c;
		end
	end

	assign out_vld = vld_s[opu_pkg::QD_STAGES-1];
	assign ovf     = ovf_s[opu_pkg::QD_STAGES-1];
	assign quo     = nq_s[opu_pkg::QD_STAGES-1];

endmodule

// File: rtl/optimizer_param_update_unit.sv
// ----------------------------------------------------------------------------
// Optimizer parameter update unit
// Element-wise plain descent or Adam update of one Q8.24 parameter and its
// two moments, fully pipelined.
// ----------------------------------------------------------------------------
// The unit takes one element in every clock cycle and never asserts busy.
// Each element's result appears as a single-cycle done beat; there is no
// back-pressure, so the receiver must take every beat as it comes. The
// latency is the same in both modes and is set by the bias-correction
// divisions, the square root and the step division, which resolve four,
// four and three result bits per pipeline stage. Register writes take
// effect at once and should be made only while no element is in flight.
// ----------------------------------------------------------------------------
module optimizer_param_update_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic signed [opu_pkg::VAL_W-1:0]    param_value,
	input  logic signed [opu_pkg::VAL_W-1:0]    gradient,
	input  logic signed [opu_pkg::VAL_W-1:0]    first_moment,
	input  logic [opu_pkg::UVAL_W-1:0]          second_moment,
	input  logic                                wr_en,
	input  logic [opu_pkg::IDX_W-1:0]           wr_index,
	input  logic [opu_pkg::REG_W-1:0]           wr_data,
	output logic                                done,
	output logic signed [opu_pkg::VAL_W-1:0]    new_param,
	output logic signed [opu_pkg::VAL_W-1:0]    new_first_moment,
	output logic [opu_pkg::UVAL_W-1:0]          new_second_moment,
	output logic                                saturated
);

	// Configuration registers.
	opu_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= opu_pkg::CFG_RESET;
		end else if (wr_en) begin
			case (opu_pkg::cfg_reg_t'(wr_index))
				opu_pkg::REG_MODE:   cfg_q.mode   <= wr_data[0];
				opu_pkg::REG_STEP:   cfg_q.step   <= wr_data;
				opu_pkg::REG_DECAY1: cfg_q.decay1 <= wr_data;
				opu_pkg::REG_DECAY2: cfg_q.decay2 <= wr_data;
				opu_pkg::REG_EPS:    cfg_q.eps    <= wr_data;
				default: ;
			endcase
		end
	end

	assign busy = 1'b0;

	// Front end: products, moments and the radicand dividend.
	logic                          fr_vld;
	logic [opu_pkg::DIV_N_W-1:0]   fr_vdiv;
	logic [55:0]                   fr_tprod;
	opu_pkg::side_t                fr_side;

	opu_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_vld        (start),
		.param_value   (param_value),
		.gradient      (gradient),
		.first_moment  (first_moment),
		.second_moment (second_moment),
		.cfg           (cfg_q),
		.out_vld       (fr_vld),
		.vdiv          (fr_vdiv),
		.tprod         (fr_tprod),
		.side          (fr_side)
	);

	// Bias correction divides: v' over 1-beta2 and the step product over 1-beta1.
	logic                          dv_vld, dt_vld;
	logic [opu_pkg::DIV_N_W-1:0]   dv_quo, dt_quo;
	logic [opu_pkg::DIV_D_W-1:0]   d1, d2;

	assign d1 = opu_pkg::ONE_Q - {1'b0, cfg_q.decay1};
	assign d2 = opu_pkg::ONE_Q - {1'b0, cfg_q.decay2};

	opu_div u_div_v (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (fr_vld),
		.dividend (fr_vdiv),
		.divisor  (d2),
		.out_vld  (dv_vld),
		.quotient (dv_quo)
	);

	opu_div u_div_t (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (fr_vld),
		.dividend (64'(fr_tprod)),
		.divisor  (d1),
		.out_vld  (dt_vld),
		.quotient (dt_quo)
	);

	// Root of the corrected second moment.
	logic                            sq_vld;
	logic [opu_pkg::SQ_ROOT_W-1:0]   sq_root;

	opu_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (dv_vld & dt_vld),
		.radicand (dv_quo),
		.out_vld  (sq_vld),
		.root     (sq_root)
	);

	// Side values and the step quotient wait alongside the long chain.
	opu_pkg::side_t              side_s [opu_pkg::SIDE_LAT];
	logic [opu_pkg::T_W-1:0]     t_s    [opu_pkg::SQ_STAGES];

	always_ff @(posedge clk) begin
		side_s[0] <= fr_side;
		for (int i = 1; i < opu_pkg::SIDE_LAT; i++) begin
			side_s[i] <= side_s[i-1];
		end
		t_s[0] <= dt_quo[opu_pkg::T_W-1:0];
		for (int i = 1; i < opu_pkg::SQ_STAGES; i++) begin
			t_s[i] <= t_s[i-1];
		end
	end

	// Scaled step over the denominator.
	logic                         qd_vld, qd_ovf;
	logic [opu_pkg::QUO_W-1:0]    qd_quo;

	opu_qdiv u_qdiv (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (sq_vld),
		.t       (t_s[opu_pkg::SQ_STAGES-1]),
		.root    (sq_root),
		.shift_a (side_s[opu_pkg::DIV_STAGES+opu_pkg::SQ_STAGES-1].shift_a),
		.eps     (cfg_q.eps),
		.out_vld (qd_vld),
		.ovf     (qd_ovf),
		.quo     (qd_quo)
	);

	// Final stage: capped update applied to the parameter, then saturation.
	opu_pkg::side_t              fin;
	logic [opu_pkg::QUO_W-1:0]   delta_c;
	logic signed [34:0]          diff_c;
	logic signed [31:0]          np_adam_c;
	logic                        satp_c;

	always_comb begin
		fin     = side_s[opu_pkg::SIDE_LAT-1];
		delta_c = (qd_ovf || (qd_quo > opu_pkg::DELTA_CAP)) ? opu_pkg::DELTA_CAP : qd_quo;
		diff_c  = fin.nm[31] ? ({{3{fin.p[31]}}, fin.p} + {2'b00, delta_c})
		                     : ({{3{fin.p[31]}}, fin.p} - {2'b00, delta_c});
		satp_c  = 1'b0;
		if (diff_c > 35'sh0_7FFF_FFFF) begin
			np_adam_c = opu_pkg::VAL_MAX;
			satp_c    = 1'b1;
		end else if (diff_c < -35'sh0_8000_0000) begin
			np_adam_c = opu_pkg::VAL_MIN;
			satp_c    = 1'b1;
		end else begin
			np_adam_c = diff_c[31:0];
		end
	end

	logic                              done_q;
	logic signed [opu_pkg::VAL_W-1:0]  new_param_q, new_fm_q;
	logic [opu_pkg::UVAL_W-1:0]        new_sm_q;
	logic                              saturated_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= qd_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (qd_vld) begin
			new_param_q <= fin.mode ? np_adam_c : fin.np_desc;
			new_fm_q    <= fin.nm;
			new_sm_q    <= fin.nv;
			saturated_q <= fin.flag | (fin.mode & satp_c);
		end
	end

	assign done              = done_q;
	assign new_param         = new_param_q;
	assign new_first_moment  = new_fm_q;
	assign new_second_moment = new_sm_q;
	assign saturated         = saturated_q;

endmodule

// File: rtl/opu_checker.sv
// ----------------------------------------------------------------------------
// Optimizer update port checker
// Watches the top-level ports for fixed latency and flag consistency.
// ----------------------------------------------------------------------------
module opu_port_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic                                busy,
	input  logic                                done,
	input  logic signed [opu_pkg::VAL_W-1:0]    new_param,
	input  logic signed [opu_pkg::VAL_W-1:0]    new_first_moment,
	input  logic [opu_pkg::UVAL_W-1:0]          new_second_moment,
	input  logic                                saturated
);

	// Every accepted beat yields a result after the fixed latency.
	a_latency_fwd: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##(opu_pkg::TOTAL_LAT) done)
		else $error("accepted beat produced no result at the fixed latency");

	// No result beat appears without an accepted beat behind it.
	a_latency_back: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, opu_pkg::TOTAL_LAT))
		else $error("result beat without a matching accepted beat");

	// A raised flag means some result sits at a range limit.
	a_sat_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(done && saturated) |->
			(new_param == opu_pkg::VAL_MAX || new_param == opu_pkg::VAL_MIN ||
			 new_first_moment == opu_pkg::VAL_MAX ||
			 new_first_moment == opu_pkg::VAL_MIN ||
			 new_second_moment == opu_pkg::UVAL_MAX))
		else $error("saturation flag with no result at a limit");

endmodule

bind optimizer_param_update_unit opu_port_checker u_opu_checker (.*);

// File: test/opu_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Optimizer update unit checker
// Watches the register write port, the start channel and the done channel,
// predicts each element's updated parameter and moments, and compares the
// done beats in order against the predictions.
// ----------------------------------------------------------------------------
module opu_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic                              busy,
	input  logic signed [opu_pkg::VAL_W-1:0]  param_value,
	input  logic signed [opu_pkg::VAL_W-1:0]  gradient,
	input  logic signed [opu_pkg::VAL_W-1:0]  first_moment,
	input  logic [opu_pkg::UVAL_W-1:0]        second_moment,
	input  logic                              wr_en,
	input  logic [opu_pkg::IDX_W-1:0]         wr_index,
	input  logic [opu_pkg::REG_W-1:0]         wr_data,
	input  logic                              done,
	input  logic signed [opu_pkg::VAL_W-1:0]  new_param,
	input  logic signed [opu_pkg::VAL_W-1:0]  new_first_moment,
	input  logic [opu_pkg::UVAL_W-1:0]        new_second_moment,
	input  logic                              saturated,
	output int                                fail_count,
	output int                                pending
);

	typedef struct {
		logic signed [opu_pkg::VAL_W-1:0] np;
		logic signed [opu_pkg::VAL_W-1:0] nm;
		logic [opu_pkg::UVAL_W-1:0]       nv;
		logic                             sat;
	} update_t;

	opu_pkg::cfg_t cfg;
	update_t       updates_due[$];

	// Clip a wide value to the signed 32-bit range.
	function automatic longint clip(longint x, output bit hit);
		hit = 1'b0;
		if (x > longint'(opu_pkg::VAL_MAX)) begin
			hit = 1'b1;
			return longint'(opu_pkg::VAL_MAX);
		end
		if (x < longint'(opu_pkg::VAL_MIN)) begin
			hit = 1'b1;
			return longint'(opu_pkg::VAL_MIN);
		end
		return x;
	endfunction

	// Integer square root, rounded down.
	function automatic logic [63:0] root_floor(logic [63:0] x);
		logic [63:0] res;
		logic [63:0] bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > x)
			bitv = bitv >> 2;
		while (bitv != 0) begin
			if (x >= res + bitv) begin
				x = x - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

	// Updated parameter and moments for one element under the given settings.
	function automatic update_t predict_update(opu_pkg::cfg_t c,
			logic signed [opu_pkg::VAL_W-1:0] p,
			logic signed [opu_pkg::VAL_W-1:0] g, logic signed [opu_pkg::VAL_W-1:0] m,
			logic [opu_pkg::UVAL_W-1:0] v);
		update_t      u;
		bit           hit;
		longint       ps, gs, ms, msum, nm, sdelta, npw;
		logic [63:0]  gmag, mmag, delta, d1, d2, gsq, vsum, nv, vq, s, den, t;
		logic [127:0] quo;
		int           a;
		ps = p;
		gs = g;
		ms = m;
		u.sat = 1'b0;
		gmag = (gs < 0) ? 64'(-gs) : 64'(gs);
		if (c.mode == 1'b0) begin
			// Plain descent: moments pass through.
			delta = (gmag * 64'(c.step)) >> opu_pkg::FRAC;
			sdelta = (gs < 0) ? -longint'(delta) : longint'(delta);
			npw = clip(ps - sdelta, hit);
			u.np = npw[opu_pkg::VAL_W-1:0];
			u.sat = hit;
			u.nm = m;
			u.nv = v;
		end else begin
			d1 = 64'(opu_pkg::ONE_Q) - 64'(c.decay1);
			d2 = 64'(opu_pkg::ONE_Q) - 64'(c.decay2);
			// First moment average, truncated toward zero.
			msum = longint'(64'(c.decay1)) * ms + longint'(d1) * gs;
			mmag = (msum < 0) ? 64'(-msum) : 64'(msum);
			mmag = mmag >> opu_pkg::FRAC;
			nm = clip((msum < 0) ? -longint'(mmag) : longint'(mmag), hit);
			u.sat = hit;
			// Second moment average, clipped to the unsigned range.
			gsq = (gmag * gmag) >> opu_pkg::FRAC;
			vsum = 64'(c.decay2) * 64'(v) + d2 * gsq;
			nv = vsum >> opu_pkg::FRAC;
			if (nv > 64'(opu_pkg::UVAL_MAX)) begin
				nv = 64'(opu_pkg::UVAL_MAX);
				u.sat = 1'b1;
			end
			// Bias-corrected root, prescaled to keep as many bits as fit.
			a = opu_pkg::FRAC;
			while (a > 0 && (nv >> (64 - 2 * a)) != 0)
				a--;
			vq = (nv << (2 * a)) / d2;
			s = root_floor(vq) << (opu_pkg::FRAC - a);
			den = s + 64'(c.eps);
			if (den == 0)
				den = 1;
			// Scaled step, capped before the subtraction.
			mmag = (nm < 0) ? 64'(-nm) : 64'(nm);
			t = (mmag * 64'(c.step)) / d1;
			quo = ({64'd0, t} << opu_pkg::FRAC) / {64'd0, den};
			delta = (quo > 128'(opu_pkg::DELTA_CAP)) ? 64'(opu_pkg::DELTA_CAP) : quo[63:0];
			sdelta = (nm < 0) ? -longint'(delta) : longint'(delta);
			npw = clip(ps - sdelta, hit);
			u.np = npw[opu_pkg::VAL_W-1:0];
			u.sat = u.sat | hit;
			u.nm = nm[opu_pkg::VAL_W-1:0];
			u.nv = nv[opu_pkg::UVAL_W-1:0];
		end
		return u;
	endfunction

	assign pending = updates_due.size();

	// Track the registers, queue a prediction per accepted beat, check done beats.
	always @(posedge clk or negedge arst_n) begin
		update_t want;
		if (!arst_n) begin
			cfg = opu_pkg::CFG_RESET;
			fail_count = 0;
			updates_due.delete();
		end else begin
			if (wr_en) begin
				case (wr_index)
					opu_pkg::REG_MODE:   cfg.mode = wr_data[0];
					opu_pkg::REG_STEP:   cfg.step = wr_data;
					opu_pkg::REG_DECAY1: cfg.decay1 = wr_data;
					opu_pkg::REG_DECAY2: cfg.decay2 = wr_data;
					opu_pkg::REG_EPS:    cfg.eps = wr_data;
					default: ;
				endcase
			end
			if (start && !busy)
				updates_due.push_back(predict_update(cfg, param_value, gradient,
					first_moment, second_moment));
			if (done) begin
				if (updates_due.size() == 0) begin
					$error("done beat with no element in flight");
					fail_count++;
				end else begin
					want = updates_due.pop_front();
					if (new_param !== want.np) begin
						$error("new_param: expected %0d, got %0d", want.np, new_param);
						fail_count++;
					end
					if (new_first_moment !== want.nm) begin
						$error("new_first_moment: expected %0d, got %0d", want.nm,
							new_first_moment);
						fail_count++;
					end
					if (new_second_moment !== want.nv) begin
						$error("new_second_moment: expected %0d, got %0d", want.nv,
							new_second_moment);
						fail_count++;
					end
					if (saturated !== want.sat) begin
						$error("saturated: expected %0b, got %0b", want.sat, saturated);
						fail_count++;
					end
				end
			end
		end
	end

endmodule

// File: test/tb_optimizer_param_update_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Optimizer update unit testbench
// Drives directed corner elements and bursts of random elements through the
// unit under many register settings in both modes; the checker compares
// every done beat and this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_optimizer_param_update_unit;

	localparam int                         WATCHDOG_LIMIT = 2000;
	localparam int                         DRAIN_CYCLES   = opu_pkg::TOTAL_LAT + 8;
	localparam int                         RANDOM_PHASES  = 8;
	localparam int                         PHASE_ITEMS    = 178;
	localparam logic [opu_pkg::IDX_W-1:0]  UNUSED_INDEX   = 3'd7;
	localparam logic [opu_pkg::REG_W-1:0]  REG_FULL       = 24'hFF_FFFF;

	logic                             clk = 1'b0;
	logic                             arst_n = 1'b0;
	logic                             start = 1'b0;
	logic                             busy;
	logic signed [opu_pkg::VAL_W-1:0] param_value = '0;
	logic signed [opu_pkg::VAL_W-1:0] gradient = '0;
	logic signed [opu_pkg::VAL_W-1:0] first_moment = '0;
	logic [opu_pkg::UVAL_W-1:0]       second_moment = '0;
	logic                             wr_en = 1'b0;
	logic [opu_pkg::IDX_W-1:0]        wr_index = '0;
	logic [opu_pkg::REG_W-1:0]        wr_data = '0;
	logic                             done;
	logic signed [opu_pkg::VAL_W-1:0] new_param;
	logic signed [opu_pkg::VAL_W-1:0] new_first_moment;
	logic [opu_pkg::UVAL_W-1:0]       new_second_moment;
	logic                             saturated;
	int                               fail_count;
	int                               pending;
	int                               idle_cycles = 0;

	always #4 clk = ~clk;

	optimizer_param_update_unit DUT (.*);

	opu_checker u_checker (.*);

	// Watchdog: end the run if no beat moves for too long.
	always @(posedge clk) begin
		if ((start && !busy) || done)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("** optimizer_param_update_unit: FAILED **");
			$finish;
		end
	end

	task automatic write_reg(logic [opu_pkg::IDX_W-1:0] idx,
			logic [opu_pkg::REG_W-1:0] data);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= data;
		@(posedge clk);
		wr_en <= 1'b0;
		@(posedge clk);
	endtask

	task automatic write_all(logic md, logic [opu_pkg::REG_W-1:0] stp,
			logic [opu_pkg::REG_W-1:0] b1, logic [opu_pkg::REG_W-1:0] b2,
			logic [opu_pkg::REG_W-1:0] eps);
		logic [31:0] r;
		r = $urandom();
		// Junk in the unused upper bits of the mode register.
		write_reg(opu_pkg::REG_MODE, {r[opu_pkg::REG_W-2:0], md});
		write_reg(opu_pkg::REG_STEP, stp);
		write_reg(opu_pkg::REG_DECAY1, b1);
		write_reg(opu_pkg::REG_DECAY2, b2);
		write_reg(opu_pkg::REG_EPS, eps);
	endtask

	// Present one element and hold it until the unit takes the beat.
	task automatic send_element(logic signed [opu_pkg::VAL_W-1:0] p,
			logic signed [opu_pkg::VAL_W-1:0] g,
			logic signed [opu_pkg::VAL_W-1:0] m, logic [opu_pkg::UVAL_W-1:0] v);
		start <= 1'b1;
		param_value <= p;
		gradient <= g;
		first_moment <= m;
		second_moment <= v;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	// Stop sending and wait until every element in flight has come back.
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic logic [opu_pkg::VAL_W-1:0] pick_value();
		case ($urandom_range(0, 5))
			0: return $urandom();
			1: return $signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000;
			2: return $signed($urandom_range(0, 32'h0000_2000)) - 32'sh0000_1000;
			3: return $urandom_range(0, 1) ? opu_pkg::VAL_MAX : opu_pkg::VAL_MIN;
			4: return $signed($urandom_range(0, 32'h2000_0000)) - 32'sh1000_0000;
			default: return $urandom() >> $urandom_range(0, 31);
		endcase
	endfunction

	function automatic logic [opu_pkg::UVAL_W-1:0] pick_moment();
		logic [opu_pkg::VAL_W-1:0] x;
		x = pick_value();
		return x[opu_pkg::UVAL_W-1:0];
	endfunction

	function automatic logic [opu_pkg::REG_W-1:0] pick_decay();
		logic [31:0] r;
		case ($urandom_range(0, 5))
			0: r = '0;
			1: r = 32'(REG_FULL);
			2: r = $urandom();
			default: r = 32'(REG_FULL) - $urandom_range(0, 24'h02_0000);
		endcase
		return r[opu_pkg::REG_W-1:0];
	endfunction

	function automatic logic [opu_pkg::REG_W-1:0] pick_reg();
		logic [31:0] r;
		case ($urandom_range(0, 4))
			0: r = 32'd1;
			1: r = 32'(REG_FULL);
			2: r = $urandom_range(1, 24'h00_0400);
			default: r = $urandom_range(1, REG_FULL);
		endcase
		return r[opu_pkg::REG_W-1:0];
	endfunction

	initial begin
		int n;
		int burst;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Descent at reset settings: sign and range extremes.
		send_element(opu_pkg::VAL_MAX, opu_pkg::VAL_MAX, opu_pkg::VAL_MAX,
			opu_pkg::UVAL_MAX);
		send_element(opu_pkg::VAL_MIN, opu_pkg::VAL_MIN, opu_pkg::VAL_MIN, '0);
		send_element(opu_pkg::VAL_MAX, opu_pkg::VAL_MIN, 32'sd0, 31'd1);
		send_element(opu_pkg::VAL_MIN, opu_pkg::VAL_MAX, -32'sd1, opu_pkg::UVAL_MAX);
		send_element(32'sd0, -32'sd1, 32'sd1, 31'd12345);
		drain();
		// Descent with the largest step saturates both ways.
		write_reg(opu_pkg::REG_STEP, REG_FULL);
		write_reg(UNUSED_INDEX, REG_FULL);
		send_element(opu_pkg::VAL_MIN, opu_pkg::VAL_MAX, 32'sd7, 31'd3);
		send_element(opu_pkg::VAL_MAX, opu_pkg::VAL_MIN, -32'sd7, opu_pkg::UVAL_MAX);
		send_element(32'sd0, 32'sh0100_0000, 32'sd0, 31'd0);
		drain();
		// Adam at reset decays: moment extremes and saturation of the second moment.
		write_all(1'b1, opu_pkg::RST_STEP, opu_pkg::RST_DECAY1, opu_pkg::RST_DECAY2,
			opu_pkg::RST_EPS);
		send_element(32'sd0, opu_pkg::VAL_MAX, opu_pkg::VAL_MAX, opu_pkg::UVAL_MAX);
		send_element(32'sd0, opu_pkg::VAL_MIN, opu_pkg::VAL_MIN, opu_pkg::UVAL_MAX);
		send_element(opu_pkg::VAL_MAX, 32'sh0100_0000, 32'sh0010_0000, 31'h0100_0000);
		send_element(opu_pkg::VAL_MIN, -32'sh0100_0000, -32'sh0010_0000, 31'd0);
		drain();
		// Zero denominator: no second moment and a zero guard term.
		write_all(1'b1, REG_FULL, '0, REG_FULL, '0);
		send_element(32'sd5, 32'sd0, 32'sd0, 31'd0);
		send_element(32'sd0, 32'sd0, 32'sh0100_0000, 31'd0);
		send_element(32'sd0, 32'sd1, -32'sd1, 31'd0);
		drain();
		// Huge update: beta1 at its top makes the bias divisor one LSB.
		write_all(1'b1, REG_FULL, REG_FULL, '0, 24'd1);
		send_element(opu_pkg::VAL_MAX, opu_pkg::VAL_MAX, opu_pkg::VAL_MAX, 31'd0);
		send_element(opu_pkg::VAL_MIN, opu_pkg::VAL_MIN, opu_pkg::VAL_MIN, 31'd1);
		send_element(32'sd0, 32'sd1, 32'sd1, opu_pkg::UVAL_MAX);
		send_element(32'sd0, -32'sd1, 32'sd0, 31'd0);
		drain();

		// Random settings, random elements in bursts with gaps.
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			if (ph == 0)
				write_all(1'b0, REG_FULL, '0, '0, REG_FULL);
			else if (ph == 1)
				write_all(1'b1, 24'd1, REG_FULL, REG_FULL, REG_FULL);
			else
				write_all(ph % 3 != 0, pick_reg(), pick_decay(), pick_decay(), pick_reg());
			n = 0;
			while (n < PHASE_ITEMS) begin
				burst = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
					: $urandom_range(1, 8);
				for (int i = 0; i < burst && n < PHASE_ITEMS; i++, n++)
					send_element(pick_value(), pick_value(), pick_value(),
						pick_moment());
				if ($urandom_range(0, 4) != 0) begin
					start <= 1'b0;
					repeat ($urandom_range(1, 12)) @(posedge clk);
				end
			end
			drain();
		end

		if (fail_count == 0)
			$display("** optimizer_param_update_unit: PASSED **");
		else
			$display("** optimizer_param_update_unit: FAILED **");
		$finish;
	end

endmodule
